// ----- design/carp_pkg.sv -----
// Shared constants for the coordinated axis rate planner.
package carp_pkg;

  localparam int FREQ_BITS = 19;
  localparam int TIME_BITS = 21;
  localparam logic [FREQ_BITS-1:0] FREQ_SAT = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_RATE_LIMIT  = 2'd0;
  localparam logic [1:0] REG_TIME_MARGIN = 2'd1;
  localparam logic [1:0] REG_STEPS_TURN  = 2'd2;

  localparam logic [7:0] RATE_LIMIT_RST  = 8'd90;
  localparam logic [9:0] TIME_MARGIN_RST = 10'd10;
  localparam logic [9:0] STEPS_TURN_RST  = 10'd200;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = 1;

endpackage

// ----- design/carp_front.sv -----
// Front end: keep the previous target, form axis distances, directions and the largest distance.
module carp_front #(
  parameter int POSITION_BITS = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [POSITION_BITS-1:0]   target_x,
  input  logic [POSITION_BITS-1:0]   target_y,
  input  logic [POSITION_BITS-1:0]   target_z,
  output logic [4*POSITION_BITS+2:0] entry
);
  import carp_pkg::*;

  localparam int P = POSITION_BITS;

  typedef struct packed {
    logic [P-1:0] dx;
    logic [P-1:0] dy;
    logic [P-1:0] dz;
    logic [2:0]   dir;
    logic [P-1:0] dmax;
  } job_t;

  logic [P-1:0] prev_x, prev_y, prev_z;
  job_t job;

  always_comb begin
    job = '0;
    job.dir[2] = target_x < prev_x;
    job.dir[1] = target_y < prev_y;
    job.dir[0] = target_z < prev_z;
    job.dx = job.dir[2] ? prev_x - target_x : target_x - prev_x;
    job.dy = job.dir[1] ? prev_y - target_y : target_y - prev_y;
    job.dz = job.dir[0] ? prev_z - target_z : target_z - prev_z;
    job.dmax = job.dx;
    if (job.dy > job.dmax) begin
      job.dmax = job.dy;
    end
    if (job.dz > job.dmax) begin
      job.dmax = job.dz;
    end
  end

  assign entry = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      prev_z <= '0;
    end else if (accept) begin
      prev_x <= target_x;
      prev_y <= target_y;
      prev_z <= target_z;
    end
  end

endmodule

// ----- design/carp_queue.sv -----
// Two-entry queue between the front end and the back end.
module carp_queue #(
  parameter int WIDTH = 71
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);
  import carp_pkg::*;

  logic [WIDTH-1:0]  slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = count == (QPTR_W+1)'(Q_DEPTH);
  assign not_empty = count != '0;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/carp_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module carp_div #(
  parameter int RW = 28,
  parameter int QW = 21,
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [RW-1:0] rem_init,
  input  logic [QW-1:0] dvd_init,
  input  logic [RW-1:0] divisor,
  input  logic [CW-1:0] steps,
  output logic          done,
  output logic [QW-1:0] quot
);
  logic [RW-1:0] rem, dsr;
  logic [QW-1:0] shreg;
  logic [CW-1:0] cnt;
  logic [RW+1:0] trial;
  logic          ge;

  always_comb begin
    trial = {1'b0, rem, shreg[QW-1]} - {2'b00, dsr};
    ge    = !trial[RW+1];
  end

  assign quot = shreg;

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      shreg <= dvd_init;
      dsr   <= divisor;
    end else if (cnt != '0) begin
      // keep the trial difference when it did not borrow
      rem   <= ge ? trial[RW-1:0] : {rem[RW-2:0], shreg[QW-1]};
      shreg <= {shreg[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/carp_back.sv -----
// Back end: move time, per-axis step frequency and the result register.
module carp_back #(
  parameter int POSITION_BITS = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  logic [4*POSITION_BITS+2:0]      job_in,
  output logic                            job_take,
  input  logic [7:0]                      rate_limit,
  input  logic [9:0]                      time_margin,
  input  logic [9:0]                      steps_per_turn,
  input  logic                            pop,
  output logic                            out_valid,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_x,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_y,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_z,
  output logic                            dir_x,
  output logic                            dir_y,
  output logic                            dir_z,
  output logic [carp_pkg::TIME_BITS-1:0]  move_time
);
  import carp_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int QW = (P + 4 > FREQ_BITS) ? P + 4 : FREQ_BITS;
  localparam int TW = P + 5;
  localparam int DW = P + 11;
  localparam int NW = P + 20;
  localparam int RW = DW;
  localparam int CW = $clog2(QW + 1);
  localparam int XW = (TW > TIME_BITS) ? TW : TIME_BITS;

  typedef struct packed {
    logic [P-1:0] dx;
    logic [P-1:0] dy;
    logic [P-1:0] dz;
    logic [2:0]   dir;
    logic [P-1:0] dmax;
  } job_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_TDIV = 8'b0000_0010,
    ST_TIME = 8'b0000_0100,
    ST_MUL1 = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_FCHK = 8'b0010_0000,
    ST_FDIV = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  job_t   jin, job;
  logic [TW-1:0]   t_reg;
  logic [DW-1:0]   den;
  logic [P+9:0]    prod;
  logic [NW-1:0]   num;
  logic [1:0]      axis;
  logic [FREQ_BITS-1:0] freq_r [3];
  logic [P-1:0]    d_sel;
  logic [7:0]      rate_eff;
  logic [P+3:0]    dmax10;
  logic [13:0]     margin10;
  logic [XW-1:0]   t_ext;
  logic            too_fast;
  logic            load_out;

  logic          div_start, div_done;
  logic [RW-1:0] div_rem, div_dsr;
  logic [QW-1:0] div_dvd, div_quot;
  logic [CW-1:0] div_steps;

  assign jin      = job_in;
  assign rate_eff = (rate_limit == '0) ? 8'd1 : rate_limit;
  assign dmax10   = (P+4)'(jin.dmax) * (P+4)'(10);
  assign margin10 = 14'(time_margin) * 14'd10;
  assign t_ext    = XW'(t_reg);
  assign too_fast = (num >> FREQ_BITS) >= NW'(den);

  always_comb begin
    case (axis)
      AXIS_X:  d_sel = job.dx;
      AXIS_Y:  d_sel = job.dy;
      default: d_sel = job.dz;
    endcase
  end

  // Start the divider: move time from IDLE, a frequency quotient from FCHK.
  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_dvd   = QW'(dmax10);
    div_dsr   = RW'(rate_eff);
    div_steps = CW'(QW);
    job_take  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          div_start = 1'b1;
          job_take  = 1'b1;
        end
      end
      ST_FCHK: begin
        div_rem   = RW'(num >> FREQ_BITS);
        div_dvd   = QW'(num[FREQ_BITS-1:0]) << (QW - FREQ_BITS);
        div_dsr   = den;
        div_steps = CW'(FREQ_BITS);
        div_start = (den != '0) && !too_fast;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  carp_div #(
    .RW(RW),
    .QW(QW),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .dvd_init (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: if (job_valid) state_next = ST_TDIV;
      ST_TDIV: if (div_done) state_next = ST_TIME;
      ST_TIME: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_FCHK;
      ST_FCHK: begin
        if (div_start) begin
          state_next = ST_FDIV;
        end else begin
          state_next = (axis == AXIS_Z) ? ST_DONE : ST_MUL1;
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          state_next = (axis == AXIS_Z) ? ST_DONE : ST_MUL1;
        end
      end
      ST_DONE: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= jin;
    end
    if (state == ST_TDIV && div_done) begin
      t_reg <= TW'(div_quot) + TW'(margin10);
    end
    if (state == ST_TIME) begin
      den  <= DW'(t_reg) * DW'(60);
      axis <= AXIS_X;
    end
    if (state == ST_MUL1) begin
      prod <= (P+10)'(d_sel) * (P+10)'(steps_per_turn);
    end
    if (state == ST_MUL2) begin
      num <= NW'(prod) * NW'(1000);
    end
    if (state == ST_FCHK && !div_start) begin
      freq_r[axis] <= (den == '0) ? '0 : FREQ_SAT;
      axis         <= axis + 1'b1;
    end
    if (state == ST_FDIV && div_done) begin
      freq_r[axis] <= div_quot[FREQ_BITS-1:0];
      axis         <= axis + 1'b1;
    end
    if (load_out) begin
      freq_x    <= freq_r[AXIS_X];
      freq_y    <= freq_r[AXIS_Y];
      freq_z    <= freq_r[AXIS_Z];
      dir_x     <= job.dir[2];
      dir_y     <= job.dir[1];
      dir_z     <= job.dir[0];
      move_time <= (t_ext > XW'(TIME_MAX)) ? TIME_MAX : t_ext[TIME_BITS-1:0];
    end
  end

endmodule

// ----- design/coordinated_axis_rate_planner_unit.sv -----
// Top level of the coordinated three-axis rate planner.
//
// - Input queue side: drive target_x/y/z and raise push; a transfer happens
//   on a rising edge with push high and full low. Each target is compared
//   with the previous one (the origin after reset).
// - Result queue side: while empty is low the oldest result sits on freq_*,
//   dir_* and move_time; pop with empty low completes the transfer.
// - Configuration: APB-style writes to rate_limit (0x0), time_margin (0x4)
//   and steps_per_turn (0x8); pready is tied high. Write only while idle.
// - Flow: the front end classifies a target in the cycle it is accepted
//   and drops it into a two-entry queue. The back end shares one bit-serial
//   divider: first the move time, a quotient of max(POSITION_BITS+4, 19)
//   bits, then for each axis the MUL1, MUL2 and FCHK states and a 19-bit
//   frequency quotient (no division when the move time is zero or the
//   frequency clips). The back end takes the next item from the queue only
//   after it has loaded the previous result.
// - The back end finishes its next item while a result waits and holds it
//   until pop frees the result register; with the queue full, full rises.
// - Synchronous reset clears the queue, the result valid flag and the previous
//   position, and restores the register defaults.
module coordinated_axis_rate_planner_unit #(
  parameter int POSITION_BITS = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [carp_pkg::CFG_AW-1:0]     paddr,
  input  logic [carp_pkg::CFG_DW-1:0]     pwdata,
  output logic [carp_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            push,
  output logic                            full,
  input  logic [POSITION_BITS-1:0]        target_x,
  input  logic [POSITION_BITS-1:0]        target_y,
  input  logic [POSITION_BITS-1:0]        target_z,
  input  logic                            pop,
  output logic                            empty,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_x,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_y,
  output logic [carp_pkg::FREQ_BITS-1:0]  freq_z,
  output logic                            dir_x,
  output logic                            dir_y,
  output logic                            dir_z,
  output logic [carp_pkg::TIME_BITS-1:0]  move_time
);
  import carp_pkg::*;

  localparam int EW = 4 * POSITION_BITS + 3;

  logic [7:0] rate_limit;
  logic [9:0] time_margin;
  logic [9:0] steps_per_turn;
  logic       cfg_wr;
  logic       accept;
  logic [EW-1:0] front_entry, q_head;
  logic       q_valid, q_take, out_valid;

  // Configuration registers; the write lands on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit     <= RATE_LIMIT_RST;
      time_margin    <= TIME_MARGIN_RST;
      steps_per_turn <= STEPS_TURN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RATE_LIMIT:  rate_limit     <= pwdata[7:0];
        REG_TIME_MARGIN: time_margin    <= pwdata[9:0];
        REG_STEPS_TURN:  steps_per_turn <= pwdata[9:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RATE_LIMIT:  prdata = CFG_DW'(rate_limit);
      REG_TIME_MARGIN: prdata = CFG_DW'(time_margin);
      REG_STEPS_TURN:  prdata = CFG_DW'(steps_per_turn);
      default:         prdata = '0;
    endcase
  end

  // Input transfer: accept whenever the decoupling queue has room.
  assign accept = push && !full;

  carp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .entry    (front_entry)
  );

  carp_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .wr_data   (front_entry),
    .rd_en     (q_take),
    .rd_data   (q_head),
    .full      (full),
    .not_empty (q_valid)
  );

  carp_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job_in         (q_head),
    .job_take       (q_take),
    .rate_limit     (rate_limit),
    .time_margin    (time_margin),
    .steps_per_turn (steps_per_turn),
    .pop            (pop && !empty),
    .out_valid      (out_valid),
    .freq_x         (freq_x),
    .freq_y         (freq_y),
    .freq_z         (freq_z),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_z          (dir_z),
    .move_time      (move_time)
  );

  // Result side looks like a queue: empty until a result is registered.
  assign empty = !out_valid;

endmodule

// ----- design/carp_checker.sv -----
// Port-level checks for the rate planner, bound to the top level.
module carp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic [carp_pkg::FREQ_BITS-1:0]  freq_x,
  input logic [carp_pkg::FREQ_BITS-1:0]  freq_y,
  input logic [carp_pkg::FREQ_BITS-1:0]  freq_z,
  input logic [carp_pkg::TIME_BITS-1:0]  move_time
);
  import carp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(move_time) && $stable(freq_x)))
    else $error("waiting result changed before transfer");

  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    (!empty && move_time == '0) |-> (freq_x == '0 && freq_y == '0 && freq_z == '0))
    else $error("nonzero frequency with zero move time");

endmodule

bind coordinated_axis_rate_planner_unit carp_checker u_carp_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .freq_x    (freq_x),
  .freq_y    (freq_y),
  .freq_z    (freq_z),
  .move_time (move_time)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: directed and random moves against a step-rate predictor.
module tb;
  import carp_pkg::*;

  localparam int POS_BITS = 17;
  localparam int MAX_CYCLES = 1_000_000;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  // Quiet time after the last result: a bit more than one full item of divider work.
  localparam int SETTLE_CYCLES = 120;
  localparam int SEG_ITEMS = 66;

  typedef enum logic {ROW_MOVE, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq_x;
    logic [FREQ_BITS-1:0] freq_y;
    logic [FREQ_BITS-1:0] freq_z;
    logic                 dir_x;
    logic                 dir_y;
    logic                 dir_z;
    logic [TIME_BITS-1:0] move_time;
  } plan_t;

  // One line of the directed table: either a register write or a move. A move
  // may carry a hand-worked plan; all others are checked against the predictor.
  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          reg_idx;
    logic [9:0]          field;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic [POS_BITS-1:0] z;
    logic                typed;
    plan_t               plan;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [CFG_DW-1:0]    pwdata;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;
  logic                 push;
  logic                 full;
  logic [POS_BITS-1:0]  target_x;
  logic [POS_BITS-1:0]  target_y;
  logic [POS_BITS-1:0]  target_z;
  logic                 pop;
  logic                 empty;
  logic [FREQ_BITS-1:0] freq_x;
  logic [FREQ_BITS-1:0] freq_y;
  logic [FREQ_BITS-1:0] freq_z;
  logic                 dir_x;
  logic                 dir_y;
  logic                 dir_z;
  logic [TIME_BITS-1:0] move_time;

  // Predictor copy of the registers and of the last accepted target.
  logic [7:0]          cfg_rate;
  logic [9:0]          cfg_margin;
  logic [9:0]          cfg_steps;
  logic [POS_BITS-1:0] last_x;
  logic [POS_BITS-1:0] last_y;
  logic [POS_BITS-1:0] last_z;

  plan_t pending_plans[$];
  row_t  dir_rows[$];
  int    errors;
  int    cycles;
  int    push_idle_pct;
  int    pop_idle_pct;

  coordinated_axis_rate_planner_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: no correct run comes close to this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Step frequency of one axis; zero move time gives zero, large values clip.
  function automatic logic [FREQ_BITS-1:0] step_rate(input logic [POS_BITS-1:0] travel,
                                                      input logic [63:0] span);
    logic [63:0] f;
    if (span == 0) return '0;
    f = 64'(travel) * 64'(cfg_steps) * 64'd1000 / (64'd60 * span);
    return (f > 64'(FREQ_SAT)) ? FREQ_SAT : f[FREQ_BITS-1:0];
  endfunction

  // Work out the plan for a move from the last target to (tx, ty, tz).
  function automatic plan_t plan_move(input logic [POS_BITS-1:0] tx, ty, tz);
    logic [POS_BITS-1:0] dx, dy, dz, dmax;
    logic [63:0]         rate;
    logic [63:0]         span;
    plan_t               p;
    p.dir_x = tx < last_x;
    p.dir_y = ty < last_y;
    p.dir_z = tz < last_z;
    dx = p.dir_x ? last_x - tx : tx - last_x;
    dy = p.dir_y ? last_y - ty : ty - last_y;
    dz = p.dir_z ? last_z - tz : tz - last_z;
    // Take the true maximum, ties included.
    dmax = dx;
    if (dy > dmax) dmax = dy;
    if (dz > dmax) dmax = dz;
    // A rate limit of zero acts as one.
    rate = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
    span = 64'(dmax) * 64'd10 / rate + 64'(cfg_margin) * 64'd10;
    // The reported time clips, but the frequencies use the full time.
    p.move_time = (span > 64'(TIME_MAX)) ? TIME_MAX : span[TIME_BITS-1:0];
    p.freq_x = step_rate(dx, span);
    p.freq_y = step_rate(dy, span);
    p.freq_z = step_rate(dz, span);
    return p;
  endfunction

  function automatic row_t move_row(input logic [POS_BITS-1:0] x, y, z);
    row_t r;
    r = '0;
    r.kind = ROW_MOVE;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic row_t fixed_row(input logic [POS_BITS-1:0] x, y, z, input plan_t p);
    row_t r;
    r = move_row(x, y, z);
    r.typed = 1'b1;
    r.plan = p;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [9:0] field);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.field = field;
    return r;
  endfunction

  // Random target for one axis: mostly short hops, some long ones, some
  // full-range jumps, repeats and the ends of the range.
  function automatic logic [POS_BITS-1:0] pick_axis(input logic [POS_BITS-1:0] from);
    int mode;
    int pos;
    mode = $urandom_range(9, 0);
    pos = int'(from);
    case (mode) inside
      [0:4]: begin
        pos = pos + $urandom_range(600, 0) - 300;
      end
      [5:6]: begin
        return POS_BITS'($urandom());
      end
      7: begin
        return from;
      end
      8: begin
        return $urandom_range(1, 0) ? POS_MAX : '0;
      end
      default: begin
        pos = pos + $urandom_range(10000, 0) - 5000;
      end
    endcase
    if (pos < 0) pos = 0;
    if (pos > int'(POS_MAX)) pos = int'(POS_MAX);
    return POS_BITS'(pos);
  endfunction

  // Report one field that differs from the plan.
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_plan(input plan_t want);
    compare_field("freq_x", want.freq_x, freq_x);
    compare_field("freq_y", want.freq_y, freq_y);
    compare_field("freq_z", want.freq_z, freq_z);
    compare_field("dir_x", want.dir_x, dir_x);
    compare_field("dir_y", want.dir_y, dir_y);
    compare_field("dir_z", want.dir_z, dir_z);
    compare_field("move_time", want.move_time, move_time);
  endtask

  // Result side: pop at random and check every result transfer in order.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99, 0) >= pop_idle_pct);
      if (pop && !empty) begin
        if (pending_plans.size() == 0) begin
          $display("%0t: unexpected result, freq_x=%0d freq_y=%0d freq_z=%0d time=%0d",
                   $time, freq_x, freq_y, freq_z, move_time);
          errors++;
        end else begin
          check_plan(pending_plans.pop_front());
        end
      end
    end
  end

  // Hold push low until every planned result has been popped, then let the
  // back end go quiet.
  task automatic settle();
    push <= 1'b0;
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle. Upper data bits carry noise
  // that the register must drop.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] field);
    logic [31:0] value;
    value = $urandom();
    case (idx)
      REG_RATE_LIMIT: begin
        value[7:0] = field[7:0];
      end
      default: begin
        value[9:0] = field;
      end
    endcase
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RATE_LIMIT: begin
        cfg_rate = value[7:0];
      end
      REG_TIME_MARGIN: begin
        cfg_margin = value[9:0];
      end
      REG_STEPS_TURN: begin
        cfg_steps = value[9:0];
      end
      default: begin
      end
    endcase
  endtask

  // Offer one target, idling first at random, and record its plan once the
  // transfer happens. Push stays high when the next move follows at once.
  task automatic send_move(input logic [POS_BITS-1:0] x, y, z,
                           input logic typed, input plan_t fixed_plan);
    if ($urandom_range(99, 0) < push_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < push_idle_pct);
    end
    push <= 1'b1;
    target_x <= x;
    target_y <= y;
    target_z <= z;
    do @(posedge clk); while (full);
    pending_plans.push_back(typed ? fixed_plan : plan_move(x, y, z));
    last_x = x;
    last_y = y;
    last_z = z;
  endtask

  task automatic configure(input logic [7:0] rate, input logic [9:0] margin,
                           input logic [9:0] steps);
    write_reg(REG_RATE_LIMIT, {2'b00, rate});
    write_reg(REG_TIME_MARGIN, margin);
    write_reg(REG_STEPS_TURN, steps);
  endtask

  initial begin
    logic [POS_BITS-1:0] nx, ny, nz;
    int                  hop;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    target_x = '0;
    target_y = '0;
    target_z = '0;
    errors = 0;
    cycles = 0;
    cfg_rate = RATE_LIMIT_RST;
    cfg_margin = TIME_MARGIN_RST;
    cfg_steps = STEPS_TURN_RST;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    push_idle_pct = 25;
    pop_idle_pct = 48;

    // Directed moves, starting from the reset defaults at the origin.
    dir_rows = '{
      // Standing still after reset: only the margin counts.
      fixed_row('0, '0, '0, plan_t'{19'd0, 19'd0, 19'd0, 1'b0, 1'b0, 1'b0, 21'd100}),
      // Equal distances on all axes, out and back.
      move_row(POS_MAX, POS_MAX, POS_MAX),
      move_row('0, '0, '0),
      move_row(POS_MAX, '0, '0),
      move_row(POS_MAX, POS_MAX, '0),
      move_row('0, 17'd1, POS_MAX - 17'd1),
      // Rate limit zero acts as one; no margin.
      cfg_row(REG_RATE_LIMIT, 10'd0),
      cfg_row(REG_TIME_MARGIN, 10'd0),
      // No motion and no margin: zero time, zero frequencies.
      fixed_row('0, 17'd1, POS_MAX - 17'd1,
                plan_t'{19'd0, 19'd0, 19'd0, 1'b0, 1'b0, 1'b0, 21'd0}),
      fixed_row(17'd1, 17'd1, POS_MAX - 17'd1,
                plan_t'{19'd333, 19'd0, 19'd0, 1'b0, 1'b0, 1'b0, 21'd10}),
      cfg_row(REG_STEPS_TURN, 10'd0),
      fixed_row(POS_MAX, 17'd1, '0,
                plan_t'{19'd0, 19'd0, 19'd0, 1'b0, 1'b0, 1'b1, 21'd1310700}),
      // Fast rate, fine steps: a short hop clips the frequency.
      cfg_row(REG_RATE_LIMIT, 10'd255),
      cfg_row(REG_STEPS_TURN, 10'd1023),
      fixed_row(POS_MAX - 17'd50, 17'd1, '0,
                plan_t'{19'd524287, 19'd0, 19'd0, 1'b1, 1'b0, 1'b0, 21'd1}),
      move_row(POS_MAX - 17'd26, '0, 17'd1),
      cfg_row(REG_TIME_MARGIN, 10'd1023),
      cfg_row(REG_RATE_LIMIT, 10'd1),
      move_row('0, POS_MAX, POS_MAX),
      cfg_row(REG_STEPS_TURN, 10'd1),
      move_row(17'd5, 17'd7, 17'd3)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].field);
      end else begin
        send_move(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].typed, dir_rows[i].plan);
      end
    end

    // Random moves in six segments, each with its own settings. Idling runs
    // sender-light, then receiver-light, then not at all.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        push_idle_pct = 48;
        pop_idle_pct = 25;
      end else if (seg == 4) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end
      case (seg)
        0: configure(RATE_LIMIT_RST, TIME_MARGIN_RST, STEPS_TURN_RST);
        1: configure(8'd255, 10'd0, 10'd1023);
        2: configure(8'd1, 10'd1023, 10'd1);
        5: configure(8'($urandom_range(255, 128)), 10'($urandom_range(3, 0)),
                     10'($urandom_range(1023, 512)));
        default: configure(8'($urandom()), 10'($urandom()), 10'($urandom()));
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(9, 0) == 0) begin
          // Same distance on every axis, each in a random direction.
          hop = $urandom_range(60000, 0);
          nx = ($urandom_range(1, 0) && int'(last_x) >= hop) ||
               int'(last_x) + hop > int'(POS_MAX) ? last_x - POS_BITS'(hop)
                                                  : last_x + POS_BITS'(hop);
          ny = ($urandom_range(1, 0) && int'(last_y) >= hop) ||
               int'(last_y) + hop > int'(POS_MAX) ? last_y - POS_BITS'(hop)
                                                  : last_y + POS_BITS'(hop);
          nz = ($urandom_range(1, 0) && int'(last_z) >= hop) ||
               int'(last_z) + hop > int'(POS_MAX) ? last_z - POS_BITS'(hop)
                                                  : last_z + POS_BITS'(hop);
        end else begin
          nx = pick_axis(last_x);
          ny = pick_axis(last_y);
          nz = pick_axis(last_z);
        end
        send_move(nx, ny, nz, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/carp_pkg.sv
design/carp_front.sv
design/carp_queue.sv
design/carp_div.sv
design/carp_back.sv
design/coordinated_axis_rate_planner_unit.sv
design/carp_checker.sv
verif/tb.sv
